// File: src/lmpm_pkg.sv
// lmpm_pkg: payload types, register indexes, layout flag bits and gamma tables
// for the led matrix pixel mapper; no dependencies
package lmpm_pkg;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [15:0]        color_565;
	} pix_in_t;

	typedef struct packed {
		logic [15:0] led_index;
		logic [23:0] led_color;
	} pix_out_t;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROTATION        = 3'd0,
		REG_LAYOUT_FLAGS    = 3'd1,
		REG_MATRIX_WIDTH    = 3'd2,
		REG_MATRIX_HEIGHT   = 3'd3,
		REG_PASSTHRU_ENABLE = 3'd4,
		REG_PASSTHRU_COLOR  = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	// bit positions in layout_flags
	localparam int LF_START_RIGHT  = 0;
	localparam int LF_START_BOTTOM = 1;
	localparam int LF_COL_MAJOR    = 2;
	localparam int LF_ZIGZAG       = 3;

	localparam int SIDE_REG_W = 9;
	localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 9'd8;

	localparam logic [7:0] GAM5 [32] = '{
		8'h00, 8'h01, 8'h02, 8'h03, 8'h05, 8'h07, 8'h09, 8'h0b,
		8'h0e, 8'h11, 8'h14, 8'h18, 8'h1d, 8'h22, 8'h28, 8'h2e,
		8'h36, 8'h3d, 8'h46, 8'h4f, 8'h59, 8'h64, 8'h6f, 8'h7c,
		8'h89, 8'h97, 8'ha6, 8'hb6, 8'hc7, 8'hd9, 8'heb, 8'hff
	};

	localparam logic [7:0] GAM6 [64] = '{
		8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h08,
		8'h09, 8'h0a, 8'h0b, 8'h0d, 8'h0e, 8'h10, 8'h12, 8'h13,
		8'h15, 8'h17, 8'h19, 8'h1b, 8'h1d, 8'h20, 8'h22, 8'h25,
		8'h27, 8'h2a, 8'h2d, 8'h30, 8'h33, 8'h37, 8'h3a, 8'h3e,
		8'h41, 8'h45, 8'h49, 8'h4d, 8'h52, 8'h56, 8'h5b, 8'h5f,
		8'h64, 8'h69, 8'h6e, 8'h74, 8'h79, 8'h7f, 8'h85, 8'h8b,
		8'h91, 8'h97, 8'h9d, 8'ha4, 8'hab, 8'hb2, 8'hb9, 8'hc0,
		8'hc7, 8'hcf, 8'hd6, 8'hde, 8'he6, 8'hee, 8'hf7, 8'hff
	};

endpackage

// File: src/led_matrix_pixel_mapper.sv
// led matrix pixel mapper: input register, one pass of mapping logic, result register
// an accepted write is held in the input register, then mapped into the result register behind valid_s2
// throughput: one pixel per cycle while out_stall is low; the index multiplier sits between the two registers
// writes outside the rotated screen give no result beat
// reset: control and config registers clear, width and height come up as 8
// depends on lmpm_pkg
module led_matrix_pixel_mapper #(
	parameter int MAX_SIDE = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  lmpm_pkg::pix_in_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output lmpm_pkg::pix_out_t                  out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lmpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [23:0]                         cfg_data
);
	import lmpm_pkg::*;

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CRD_W  = $clog2(MAX_SIDE);
	localparam int PROD_W = 2 * SIDE_W;

	// config registers
	logic [1:0]            rotation_q;
	logic [3:0]            layout_flags_q;
	logic [SIDE_REG_W-1:0] matrix_width_q;
	logic [SIDE_REG_W-1:0] matrix_height_q;
	logic                  passthru_enable_q;
	logic [23:0]           passthru_color_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q        <= '0;
			layout_flags_q    <= '0;
			matrix_width_q    <= SIDE_RESET;
			matrix_height_q   <= SIDE_RESET;
			passthru_enable_q <= 1'b0;
			passthru_color_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ROTATION:        rotation_q        <= cfg_data[1:0];
				REG_LAYOUT_FLAGS:    layout_flags_q    <= cfg_data[3:0];
				REG_MATRIX_WIDTH:    matrix_width_q    <= cfg_data[SIDE_REG_W-1:0];
				REG_MATRIX_HEIGHT:   matrix_height_q   <= cfg_data[SIDE_REG_W-1:0];
				REG_PASSTHRU_ENABLE: passthru_enable_q <= cfg_data[0];
				REG_PASSTHRU_COLOR:  passthru_color_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic    valid_s1;
	pix_in_t data_s1;
	logic    valid_s2;
	logic    advance;
	logic    hit;
	pix_out_t result;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1 && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && hit) begin
			out_data <= result;
		end
	end

	assign out_valid = valid_s2;

	// mapping logic between the two registers
	always_comb begin
		logic [SIDE_W-1:0] w;
		logic [SIDE_W-1:0] h;
		logic [SIDE_W-1:0] sw;
		logic [SIDE_W-1:0] sh;
		logic [SIDE_W-1:0] w_m1;
		logic [SIDE_W-1:0] h_m1;
		logic [CRD_W-1:0]  x;
		logic [CRD_W-1:0]  y;
		logic [CRD_W-1:0]  px;
		logic [CRD_W-1:0]  py;
		logic [CRD_W-1:0]  minor;
		logic [CRD_W-1:0]  major;
		logic [CRD_W-1:0]  tmp;
		logic [SIDE_W-1:0] scale;
		logic [SIDE_W-1:0] major_p;
		logic [PROD_W-1:0] prod;
		logic [PROD_W-1:0] idx;
		logic              reverse;

		// sides above MAX_SIDE saturate
		w = (matrix_width_q > SIDE_REG_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
			: matrix_width_q[SIDE_W-1:0];
		h = (matrix_height_q > SIDE_REG_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
			: matrix_height_q[SIDE_W-1:0];
		sw = rotation_q[0] ? h : w;
		sh = rotation_q[0] ? w : h;
		w_m1 = w - 1'b1;
		h_m1 = h - 1'b1;

		hit = !data_s1.pos_x[15] && !data_s1.pos_y[15]
			&& (data_s1.pos_x[14:0] < 15'(sw))
			&& (data_s1.pos_y[14:0] < 15'(sh));

		// coordinates are below MAX_SIDE on a hit
		x = data_s1.pos_x[CRD_W-1:0];
		y = data_s1.pos_y[CRD_W-1:0];

		unique case (rot_t'(rotation_q))
			ROT_90: begin
				px = CRD_W'(w_m1 - SIDE_W'(y));
				py = x;
			end
			ROT_180: begin
				px = CRD_W'(w_m1 - SIDE_W'(x));
				py = CRD_W'(h_m1 - SIDE_W'(y));
			end
			ROT_270: begin
				px = y;
				py = CRD_W'(h_m1 - SIDE_W'(x));
			end
			default: begin
				px = x;
				py = y;
			end
		endcase

		minor = layout_flags_q[LF_START_RIGHT] ? CRD_W'(w_m1 - SIDE_W'(px)) : px;
		major = layout_flags_q[LF_START_BOTTOM] ? CRD_W'(h_m1 - SIDE_W'(py)) : py;
		if (layout_flags_q[LF_COL_MAJOR]) begin
			tmp   = minor;
			minor = major;
			major = tmp;
			scale = h;
		end else begin
			tmp   = '0;
			scale = w;
		end

		// odd lines of a zigzag run backwards
		reverse = layout_flags_q[LF_ZIGZAG] && major[0];
		major_p = reverse ? SIDE_W'(major) + 1'b1 : SIDE_W'(major);
		prod    = PROD_W'(major_p) * PROD_W'(scale);
		idx     = reverse ? prod - 1'b1 - PROD_W'(minor) : prod + PROD_W'(minor);

		result.led_index = 16'(idx);
		result.led_color = passthru_enable_q ? passthru_color_q
			: {GAM5[data_s1.color_565[15:11]],
			   GAM6[data_s1.color_565[10:5]],
			   GAM5[data_s1.color_565[4:0]]};
	end

endmodule

// File: tb/sv/led_matrix_pixel_mapper_tb.sv
// testbench for led_matrix_pixel_mapper: random and directed pixel writes over many
// register settings, checked beat by beat against an in-bench strip index and color mapper
// depends on lmpm_pkg and the led_matrix_pixel_mapper rtl
module led_matrix_pixel_mapper_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lmpm_pkg::*;

	localparam int MAX_SIDE     = 256;
	localparam int NUM_PHASES   = 16;
	localparam int PHASE_PIXELS = 64;
	localparam int DRAIN_GAP    = 6;
	localparam int HOLD_CYCLES  = 120;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_PRINTED  = 40;

	// indexes past the register list, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_NONE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NONE_7 = 3'd7;

	localparam logic [7:0] gamma5_lut [32] = '{
		8'h00, 8'h01, 8'h02, 8'h03, 8'h05, 8'h07, 8'h09, 8'h0b,
		8'h0e, 8'h11, 8'h14, 8'h18, 8'h1d, 8'h22, 8'h28, 8'h2e,
		8'h36, 8'h3d, 8'h46, 8'h4f, 8'h59, 8'h64, 8'h6f, 8'h7c,
		8'h89, 8'h97, 8'ha6, 8'hb6, 8'hc7, 8'hd9, 8'heb, 8'hff
	};
	localparam logic [7:0] gamma6_lut [64] = '{
		8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h08,
		8'h09, 8'h0a, 8'h0b, 8'h0d, 8'h0e, 8'h10, 8'h12, 8'h13,
		8'h15, 8'h17, 8'h19, 8'h1b, 8'h1d, 8'h20, 8'h22, 8'h25,
		8'h27, 8'h2a, 8'h2d, 8'h30, 8'h33, 8'h37, 8'h3a, 8'h3e,
		8'h41, 8'h45, 8'h49, 8'h4d, 8'h52, 8'h56, 8'h5b, 8'h5f,
		8'h64, 8'h69, 8'h6e, 8'h74, 8'h79, 8'h7f, 8'h85, 8'h8b,
		8'h91, 8'h97, 8'h9d, 8'ha4, 8'hab, 8'hb2, 8'hb9, 8'hc0,
		8'hc7, 8'hcf, 8'hd6, 8'hde, 8'he6, 8'hee, 8'hf7, 8'hff
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	pix_in_t              in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	pix_out_t             out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [23:0]          cfg_data = '0;

	// mapper settings as the block should hold them
	rot_t                 m_rot = ROT_0;
	logic [3:0]           m_flags = '0;
	logic [8:0]           m_width = SIDE_RESET;
	logic [8:0]           m_height = SIDE_RESET;
	logic                 m_pt_en = 1'b0;
	logic [23:0]          m_pt_color = '0;

	pix_in_t              pixel_q [$];
	pix_out_t             expected_leds [$];
	pix_out_t             mapped_led;
	pix_out_t             want_led;
	pix_in_t              drv_pixel;
	logic                 drv_valid;
	bit                   idle_on = 1'b1;
	int                   rx_hold_left = 0;
	int                   err_cnt = 0;
	int                   n_accepted = 0;
	int                   n_checked = 0;
	int                   cycle_cnt = 0;

	led_matrix_pixel_mapper #(
		.MAX_SIDE(MAX_SIDE)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic int eff_side(logic [8:0] v);
		return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
	endfunction

	// strip position and color of one pixel write, 0 when it falls off the screen
	function automatic bit map_pixel(input pix_in_t pix, output pix_out_t led);
		int sx, sy, w, h, sw, sh, px, py, minor, major, tmp, scale, idx;
		sx = $signed(pix.pos_x);
		sy = $signed(pix.pos_y);
		w = eff_side(m_width);
		h = eff_side(m_height);
		sw = m_rot[0] ? h : w;
		sh = m_rot[0] ? w : h;
		led = '0;
		if (sx < 0 || sy < 0 || sx >= sw || sy >= sh)
			return 1'b0;
		case (m_rot)
			ROT_90: begin
				px = w - 1 - sy;
				py = sx;
			end
			ROT_180: begin
				px = w - 1 - sx;
				py = h - 1 - sy;
			end
			ROT_270: begin
				px = sy;
				py = h - 1 - sx;
			end
			default: begin
				px = sx;
				py = sy;
			end
		endcase
		minor = px;
		major = py;
		if (m_flags[LF_START_RIGHT])
			minor = w - 1 - minor;
		if (m_flags[LF_START_BOTTOM])
			major = h - 1 - major;
		if (m_flags[LF_COL_MAJOR]) begin
			tmp = minor;
			minor = major;
			major = tmp;
			scale = h;
		end else begin
			scale = w;
		end
		// odd lines of a zigzag strip run backwards
		if (m_flags[LF_ZIGZAG] && major[0])
			idx = (major + 1) * scale - 1 - minor;
		else
			idx = major * scale + minor;
		led.led_index = idx[15:0];
		led.led_color = m_pt_en ? m_pt_color : {gamma5_lut[pix.color_565[15:11]],
			gamma6_lut[pix.color_565[10:5]], gamma5_lut[pix.color_565[4:0]]};
		return 1'b1;
	endfunction

	function automatic int border_coord(int n);
		case ($urandom_range(4))
			0: return -1;
			1: return 0;
			2: return n - 1;
			3: return n;
			default: return n + 1;
		endcase
	endfunction

	function automatic pix_in_t rand_pixel();
		pix_in_t pix;
		int sw, sh, pick;
		sw = m_rot[0] ? eff_side(m_height) : eff_side(m_width);
		sh = m_rot[0] ? eff_side(m_width) : eff_side(m_height);
		pick = $urandom_range(99);
		pix.color_565 = 16'($urandom());
		pix.pos_x = 16'($urandom());
		pix.pos_y = 16'($urandom());
		if (pick < 75 && sw > 0 && sh > 0) begin
			pix.pos_x = 16'($urandom_range(sw - 1));
			pix.pos_y = 16'($urandom_range(sh - 1));
		end else if (pick < 90) begin
			pix.pos_x = 16'(border_coord(sw));
			pix.pos_y = 16'(border_coord(sh));
		end
		return pix;
	endfunction

	task automatic push_pixel(input int x, input int y, input logic [15:0] color);
		pix_in_t pix;
		pix.pos_x = 16'(x);
		pix.pos_y = 16'(y);
		pix.color_565 = color;
		pixel_q.push_back(pix);
	endtask

	task automatic push_corners();
		int sw, sh;
		sw = m_rot[0] ? eff_side(m_height) : eff_side(m_width);
		sh = m_rot[0] ? eff_side(m_width) : eff_side(m_height);
		push_pixel(0, 0, 16'($urandom()));
		push_pixel(sw - 1, sh - 1, 16'($urandom()));
		push_pixel(sw - 1, 0, 16'($urandom()));
		push_pixel(0, sh - 1, 16'($urandom()));
		push_pixel(sw, 0, 16'($urandom()));
		push_pixel(0, sh, 16'($urandom()));
		push_pixel(-1, sh - 1, 16'($urandom()));
	endtask

	task automatic flag_error(input string what);
		if (err_cnt < MAX_PRINTED)
			$display("ERROR @%0t: %s", $realtime, what);
		err_cnt++;
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ROTATION:        m_rot = rot_t'(val[1:0]);
			REG_LAYOUT_FLAGS:    m_flags = val[3:0];
			REG_MATRIX_WIDTH:    m_width = val[8:0];
			REG_MATRIX_HEIGHT:   m_height = val[8:0];
			REG_PASSTHRU_ENABLE: m_pt_en = val[0];
			REG_PASSTHRU_COLOR:  m_pt_color = val;
			default: ;
		endcase
	endtask

	// wait until every offered pixel is taken and every mapped beat is back
	task automatic settle(input bit with_gap);
		do
			@(negedge clk);
		while (pixel_q.size() != 0 || in_valid || expected_leds.size() != 0);
		if (with_gap)
			repeat (DRAIN_GAP) @(negedge clk);
	endtask

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			drv_valid = in_valid;
			drv_pixel = in_data;
			if (in_valid && !in_stall) begin
				n_accepted++;
				if (map_pixel(in_data, mapped_led))
					expected_leds.push_back(mapped_led);
				drv_valid = 1'b0;
			end
			if (!drv_valid && pixel_q.size() != 0 &&
					!(idle_on && $urandom_range(99) < 35)) begin
				drv_pixel = pixel_q.pop_front();
				drv_valid = 1'b1;
			end
			in_valid <= drv_valid;
			in_data <= drv_pixel;
		end
	end

	// result monitor and output stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_leds.size() == 0) begin
					flag_error($sformatf("unexpected beat index %0d color %06h",
						out_data.led_index, out_data.led_color));
				end else begin
					want_led = expected_leds.pop_front();
					n_checked++;
					if (out_data.led_index !== want_led.led_index)
						flag_error($sformatf("led_index %0d, want %0d",
							out_data.led_index, want_led.led_index));
					if (out_data.led_color !== want_led.led_color)
						flag_error($sformatf("led_color %06h, want %06h",
							out_data.led_color, want_led.led_color));
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left = rx_hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < 35);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("led_matrix_pixel_mapper verification failed");
			$finish;
		end
	end

	initial begin
		int wv, hv;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: 8 by 8, no rotation, progressive rows, gamma colors
		push_pixel(0, 0, 16'h0000);
		push_pixel(7, 7, 16'hffff);
		push_pixel(7, 0, 16'hf800);
		push_pixel(0, 7, 16'h07e0);
		push_pixel(3, 4, 16'h001f);
		push_pixel(5, 2, 16'ha5a5);
		push_pixel(2, 5, 16'h5a5a);
		push_pixel(8, 0, 16'hffff);
		push_pixel(0, 8, 16'hffff);
		push_pixel(-1, 0, 16'h1234);
		push_pixel(0, -1, 16'h1234);
		push_pixel(-32768, -32768, 16'hffff);
		push_pixel(32767, 32767, 16'hffff);
		push_pixel(32767, 0, 16'h0001);
		push_pixel(0, -32768, 16'h8000);

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle(1'b1);
			case (p)
				0: begin wv = 256; hv = 256; end
				1: begin wv = 1; hv = 1; end
				2: begin wv = 1; hv = 256; end
				3: begin wv = 256; hv = 1; end
				4: begin wv = 0; hv = 8; end
				5: begin wv = 511; hv = 300; end
				6: begin wv = 5; hv = 0; end
				default: begin
					wv = ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(1, 24);
					hv = ($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(1, 24);
				end
			endcase
			// upper data bits are random, the block keeps only the register width
			set_reg(REG_ROTATION, {22'($urandom()), 2'(p + p / 4)});
			set_reg(REG_LAYOUT_FLAGS, {20'($urandom()), 4'(p)});
			set_reg(REG_MATRIX_WIDTH, {15'($urandom()), 9'(wv)});
			set_reg(REG_MATRIX_HEIGHT, {15'($urandom()), 9'(hv)});
			set_reg(REG_PASSTHRU_ENABLE, {23'($urandom()), 1'(p % 3 == 1)});
			set_reg(REG_PASSTHRU_COLOR, (p == 1) ? 24'hffffff :
				(p == 4) ? 24'h000000 : 24'($urandom()));
			set_reg(REG_NONE_6, 24'($urandom()));
			set_reg(REG_NONE_7, 24'($urandom()));
			@(negedge clk);

			idle_on = !(p == 3 || p == 9);
			// receiver holds off while the sender keeps offering, so the block backs up
			if (p == 9)
				rx_hold_left = HOLD_CYCLES;
			push_corners();
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				// sender pauses halfway until every mapped beat has come back
				if (p == 12 && i == PHASE_PIXELS / 2)
					settle(1'b0);
				pixel_q.push_back(rand_pixel());
			end
		end

		settle(1'b1);
		idle_on = 1'b1;
		if (expected_leds.size() != 0)
			flag_error($sformatf("%0d mapped beats never came", expected_leds.size()));
		$display("%0d pixel writes over %0d register settings: %0d mapped beats checked, %0d dropped",
			n_accepted, NUM_PHASES + 1, n_checked, n_accepted - n_checked);
		$display("all rotations and layout flag sets, sides 0 to 511, gamma and pass-through colors");
		if (err_cnt == 0)
			$display("led_matrix_pixel_mapper verification clean");
		else
			$display("led_matrix_pixel_mapper verification failed");
		$finish;
	end

endmodule
